// ----- rtl/ttw_pkg.sv -----
// Shared types, constants and the microcode table of the text terminal writer.
// Used by every module of the block but ttw_ram; depends on nothing else.

package ttw_pkg;

    // Fixed field widths of the command and result transactions.
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 11;
    localparam int LOC_W  = 11;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_BKSP  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    // Microcode step addresses.
    localparam upc_t ST_INIT       = 5'd0;
    localparam upc_t ST_FETCH      = 5'd1;
    localparam upc_t ST_PUT        = 5'd2;
    localparam upc_t ST_PUT_RD     = 5'd3;
    localparam upc_t ST_PUT_WR     = 5'd4;
    localparam upc_t ST_PUT_NL     = 5'd5;
    localparam upc_t ST_PUT_CHK    = 5'd6;
    localparam upc_t ST_CHK_DONE   = 5'd7;
    localparam upc_t ST_SCROLL     = 5'd8;
    localparam upc_t ST_SCR_RD     = 5'd9;
    localparam upc_t ST_SCR_COPY   = 5'd10;
    localparam upc_t ST_SCR_BLANK  = 5'd11;
    localparam upc_t ST_SCR_END    = 5'd12;
    localparam upc_t ST_CLEAR      = 5'd13;
    localparam upc_t ST_CLR_END    = 5'd14;
    localparam upc_t ST_READ       = 5'd15;
    localparam upc_t ST_READ_LATCH = 5'd16;
    localparam upc_t ST_BKSP       = 5'd17;
    localparam upc_t ST_BK_COL     = 5'd18;
    localparam upc_t ST_BK_PREV    = 5'd19;
    localparam upc_t ST_BSCAN      = 5'd20;
    localparam upc_t ST_BK_TEST    = 5'd21;
    localparam upc_t ST_BK_LAST    = 5'd22;
    localparam upc_t ST_BK_STEP    = 5'd23;
    localparam upc_t ST_BFOUND     = 5'd24;
    localparam upc_t ST_BDEC       = 5'd25;
    localparam upc_t ST_BNONE      = 5'd26;
    localparam upc_t ST_BERASE     = 5'd27;
    localparam upc_t ST_ER_RD      = 5'd28;
    localparam upc_t ST_ER_WR      = 5'd29;
    localparam upc_t ST_DONE       = 5'd30;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_BRANCH,
        SEQ_LOOP,
        SEQ_FETCH,
        SEQ_DONE
    } seq_t;

    typedef enum logic [3:0] {
        COND_NONE,
        COND_IS_NL,
        COND_SCR_PEND,
        COND_LAST_CELL,
        COND_LAST_COPY,
        COND_ADDR_OOR,
        COND_HOME,
        COND_COL_NZ,
        COND_CHAR_NS,
        COND_KCNT_ZERO
    } cond_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_PTR,
        RD_PTR_C,
        RD_PTR_C1,
        RD_CMD
    } rsel_t;

    typedef enum logic [2:0] {
        WR_RESET,
        WR_BLANK,
        WR_COPY,
        WR_PUTCH,
        WR_SPACE
    } wsel_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_INC,
        PTR_DEC,
        PTR_CLR,
        PTR_CURSOR,
        PTR_ROW_END
    } ptr_op_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ADV_CHAR,
        CUR_ADV_NL,
        CUR_PREV_ROW,
        CUR_COL_SCAN,
        CUR_COL_DEC,
        CUR_COL_CLR
    } cur_op_t;

    typedef struct packed {
        seq_t    seq;
        cond_t   cond;
        upc_t    target;
        logic    we;
        wsel_t   wsel;
        rsel_t   rsel;
        ptr_op_t ptr_op;
        cur_op_t cur_op;
        logic    latch_data;
    } uword_t;

    typedef struct packed {
        logic is_nl;
        logic scr_pend;
        logic last_cell;
        logic last_copy;
        logic addr_oor;
        logic home;
        logic col_nz;
        logic char_ns;
        logic kcnt_zero;
    } flags_t;

    // The control program. Loops advance when their condition is true and
    // otherwise repeat the same step.
    function automatic uword_t ucode_rom(input upc_t pc);
        uword_t w;
        w = '0;
        case (pc)
            ST_INIT:
            begin
                w.we = 1'b1;
                w.wsel = WR_RESET;
                w.ptr_op = PTR_INC;
                w.seq = SEQ_LOOP;
                w.cond = COND_LAST_CELL;
            end
            ST_FETCH:
            begin
                w.seq = SEQ_FETCH;
            end
            ST_PUT:
            begin
                w.ptr_op = PTR_CURSOR;
                w.seq = SEQ_BRANCH;
                w.cond = COND_IS_NL;
                w.target = ST_PUT_NL;
            end
            ST_PUT_RD:
            begin
                w.rsel = RD_PTR;
            end
            ST_PUT_WR:
            begin
                w.we = 1'b1;
                w.wsel = WR_PUTCH;
                w.cur_op = CUR_ADV_CHAR;
                w.seq = SEQ_JUMP;
                w.target = ST_PUT_CHK;
            end
            ST_PUT_NL:
            begin
                w.cur_op = CUR_ADV_NL;
            end
            ST_PUT_CHK:
            begin
                w.seq = SEQ_BRANCH;
                w.cond = COND_SCR_PEND;
                w.target = ST_SCROLL;
            end
            ST_CHK_DONE:
            begin
                w.seq = SEQ_JUMP;
                w.target = ST_DONE;
            end
            ST_SCROLL:
            begin
                w.ptr_op = PTR_CLR;
            end
            ST_SCR_RD:
            begin
                w.rsel = RD_PTR_C;
            end
            ST_SCR_COPY:
            begin
                w.we = 1'b1;
                w.wsel = WR_COPY;
                w.rsel = RD_PTR_C1;
                w.ptr_op = PTR_INC;
                w.seq = SEQ_LOOP;
                w.cond = COND_LAST_COPY;
            end
            ST_SCR_BLANK:
            begin
                w.we = 1'b1;
                w.wsel = WR_BLANK;
                w.ptr_op = PTR_INC;
                w.seq = SEQ_LOOP;
                w.cond = COND_LAST_CELL;
            end
            ST_SCR_END:
            begin
                w.seq = SEQ_JUMP;
                w.target = ST_DONE;
            end
            ST_CLEAR:
            begin
                w.we = 1'b1;
                w.wsel = WR_BLANK;
                w.ptr_op = PTR_INC;
                w.seq = SEQ_LOOP;
                w.cond = COND_LAST_CELL;
            end
            ST_CLR_END:
            begin
                w.seq = SEQ_JUMP;
                w.target = ST_DONE;
            end
            ST_READ:
            begin
                w.rsel = RD_CMD;
                w.seq = SEQ_BRANCH;
                w.cond = COND_ADDR_OOR;
                w.target = ST_DONE;
            end
            ST_READ_LATCH:
            begin
                w.latch_data = 1'b1;
                w.seq = SEQ_JUMP;
                w.target = ST_DONE;
            end
            ST_BKSP:
            begin
                w.seq = SEQ_BRANCH;
                w.cond = COND_HOME;
                w.target = ST_DONE;
            end
            ST_BK_COL:
            begin
                w.seq = SEQ_BRANCH;
                w.cond = COND_COL_NZ;
                w.target = ST_BDEC;
            end
            ST_BK_PREV:
            begin
                w.ptr_op = PTR_ROW_END;
                w.cur_op = CUR_PREV_ROW;
            end
            ST_BSCAN:
            begin
                w.rsel = RD_PTR;
            end
            ST_BK_TEST:
            begin
                w.seq = SEQ_BRANCH;
                w.cond = COND_CHAR_NS;
                w.target = ST_BFOUND;
            end
            ST_BK_LAST:
            begin
                w.seq = SEQ_BRANCH;
                w.cond = COND_KCNT_ZERO;
                w.target = ST_BNONE;
            end
            ST_BK_STEP:
            begin
                w.ptr_op = PTR_DEC;
                w.seq = SEQ_JUMP;
                w.target = ST_BSCAN;
            end
            ST_BFOUND:
            begin
                w.cur_op = CUR_COL_SCAN;
                w.seq = SEQ_JUMP;
                w.target = ST_BERASE;
            end
            ST_BDEC:
            begin
                w.cur_op = CUR_COL_DEC;
                w.seq = SEQ_JUMP;
                w.target = ST_BERASE;
            end
            ST_BNONE:
            begin
                w.cur_op = CUR_COL_CLR;
            end
            ST_BERASE:
            begin
                w.ptr_op = PTR_CURSOR;
            end
            ST_ER_RD:
            begin
                w.rsel = RD_PTR;
            end
            ST_ER_WR:
            begin
                w.we = 1'b1;
                w.wsel = WR_SPACE;
            end
            ST_DONE:
            begin
                w.seq = SEQ_DONE;
            end
            default:
            begin
                w.seq = SEQ_JUMP;
                w.target = ST_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/text_terminal_writer.sv -----
// Top level of the text terminal writer: a microcoded command engine over a
// cell store. Depends on ttw_pkg, ttw_sequencer, ttw_datapath and ttw_ram.
//
//  Channel   Direction  Handshake            Payload
//  command   in         in_valid / in_stall  op, char_code, cell_address
//  result    out        out_valid/out_stall  cursor_index, cursor_row,
//                                            cursor_column, read_data, scrolled
//  config    in         cfg_write            cfg_data (blank attribute)
//
// After reset the store is swept to blank cells before the first command is
// taken; configuration writes are taken throughout.
// A result waits in its output register while the next command is accepted.

module text_terminal_writer
    import ttw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [ADDR_W-1:0] cell_address,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [LOC_W-1:0]  cursor_index,
    output logic [ROW_W-1:0]  cursor_row,
    output logic [COL_W-1:0]  cursor_column,
    output logic [CELL_W-1:0] read_data,
    output logic              scrolled,
    input  logic              cfg_write,
    input  logic [ATTR_W-1:0] cfg_data
);

    uword_t uw;
    flags_t flags;
    logic   accept;
    logic   emit;

    ttw_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .out_stall (out_stall),
        .flags     (flags),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .uw        (uw),
        .accept    (accept),
        .emit      (emit)
    );

    ttw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .uw              (uw),
        .accept          (accept),
        .emit            (emit),
        .char_code       (char_code),
        .cell_address    (cell_address),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .flags           (flags),
        .cursor_index    (cursor_index),
        .cursor_row      (cursor_row),
        .cursor_column   (cursor_column),
        .read_data       (read_data),
        .scrolled        (scrolled)
    );

endmodule

// ----- rtl/ttw_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the screen cell store.

module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ttw_datapath.sv -----
// Datapath of the text terminal writer: cursor, sweep pointer, scan counter,
// command and result registers, and the cell store. Depends on ttw_pkg, ttw_ram.

module ttw_datapath
    import ttw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  uword_t            uw,
    input  logic              accept,
    input  logic              emit,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [ADDR_W-1:0] cell_address,
    input  logic              cfg_write,
    input  logic [ATTR_W-1:0] cfg_data,
    output flags_t            flags,
    output logic [LOC_W-1:0]  cursor_index,
    output logic [ROW_W-1:0]  cursor_row,
    output logic [COL_W-1:0]  cursor_column,
    output logic [CELL_W-1:0] read_data,
    output logic              scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int IOW   = (LOC_W > ADDR_W) ? LOC_W : ADDR_W;
    localparam int XW    = (AW > IOW) ? AW : IOW;
    localparam int RXW   = (RW > ROW_W) ? RW : ROW_W;
    localparam int CXW   = (CW > COL_W) ? CW : COL_W;

    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     kcnt_reg, kcnt_next;
    logic              scr_reg, scr_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic [CHAR_W-1:0] cmd_ch_reg;
    logic [ADDR_W-1:0] cmd_addr_reg;
    logic [CELL_W-1:0] data_reg, data_next;
    logic [LOC_W-1:0]  out_loc_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [CELL_W-1:0] out_data_reg;
    logic              out_scr_reg;

    logic [XW-1:0]     row_base_x;
    logic [XW-1:0]     cur_addr_x;
    logic [XW-1:0]     row_end_x;
    logic [XW-1:0]     cmd_addr_x;
    logic [RXW-1:0]    row_x;
    logic [CXW-1:0]    col_x;
    logic              at_last_col;
    logic              at_last_row;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;

    assign row_base_x  = XW'(row_reg) * XW'(COLUMNS);
    assign cur_addr_x  = row_base_x + XW'(col_reg);
    assign row_end_x   = row_base_x - XW'(1);
    assign cmd_addr_x  = XW'(cmd_addr_reg);
    assign row_x       = RXW'(row_reg);
    assign col_x       = CXW'(col_reg);
    assign at_last_col = (col_reg == CW'(COLUMNS - 1));
    assign at_last_row = (row_reg == RW'(ROWS - 1));

    assign flags.is_nl     = (cmd_ch_reg == NEWLINE_CHAR);
    assign flags.scr_pend  = scr_reg;
    assign flags.last_cell = (ptr_reg == AW'(CELLS - 1));
    assign flags.last_copy = (ptr_reg == AW'(CELLS - COLUMNS - 1));
    assign flags.addr_oor  = (cmd_addr_x >= XW'(CELLS));
    assign flags.home      = (row_reg == '0) && (col_reg == '0);
    assign flags.col_nz    = (col_reg != '0);
    assign flags.char_ns   = (ram_rdata[CHAR_W-1:0] != SPACE_CHAR);
    assign flags.kcnt_zero = (kcnt_reg == '0);

    always_comb
    begin
        case (uw.rsel)
            RD_PTR:    ram_raddr = ptr_reg;
            RD_PTR_C:  ram_raddr = ptr_reg + AW'(COLUMNS);
            RD_PTR_C1: ram_raddr = ptr_reg + AW'(COLUMNS + 1);
            RD_CMD:    ram_raddr = cmd_addr_x[AW-1:0];
            default:   ram_raddr = ptr_reg;
        endcase
    end

    always_comb
    begin
        case (uw.wsel)
            WR_RESET: ram_wdata = {RESET_ATTR, SPACE_CHAR};
            WR_BLANK: ram_wdata = {attr_reg, SPACE_CHAR};
            WR_COPY:  ram_wdata = ram_rdata;
            WR_PUTCH: ram_wdata = {ram_rdata[CELL_W-1:CHAR_W], cmd_ch_reg};
            WR_SPACE: ram_wdata = {ram_rdata[CELL_W-1:CHAR_W], SPACE_CHAR};
            default:  ram_wdata = ram_rdata;
        endcase
    end

    ttw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (uw.we),
        .waddr (ptr_reg),
        .wdata (ram_wdata),
        .re    (uw.rsel != RD_NONE),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Cursor movement. Running off the last row leaves the cursor there and
    // flags the scroll, which the program then carries out.
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        scr_next = scr_reg;
        if (accept)
        begin
            scr_next = 1'b0;
        end
        case (uw.cur_op)
            CUR_ADV_CHAR:
            begin
                if (at_last_col)
                begin
                    col_next = '0;
                    if (at_last_row)
                    begin
                        scr_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + RW'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            CUR_ADV_NL:
            begin
                col_next = '0;
                if (at_last_row)
                begin
                    scr_next = 1'b1;
                end
                else
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            CUR_PREV_ROW:
            begin
                row_next = row_reg - RW'(1);
            end
            CUR_COL_SCAN:
            begin
                if (ram_rdata[CHAR_W-1:0] == NEWLINE_CHAR)
                begin
                    col_next = '0;
                end
                else if (kcnt_reg == CW'(COLUMNS - 1))
                begin
                    col_next = CW'(COLUMNS - 1);
                end
                else
                begin
                    col_next = kcnt_reg + CW'(1);
                end
            end
            CUR_COL_DEC:
            begin
                col_next = col_reg - CW'(1);
            end
            CUR_COL_CLR:
            begin
                col_next = '0;
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase
    end

    // The scan counter follows the pointer across the previous row, so it
    // always holds the column of the cell being examined.
    always_comb
    begin
        ptr_next  = ptr_reg;
        kcnt_next = kcnt_reg;
        case (uw.ptr_op)
            PTR_INC:     ptr_next = ptr_reg + AW'(1);
            PTR_DEC:
            begin
                ptr_next  = ptr_reg - AW'(1);
                kcnt_next = kcnt_reg - CW'(1);
            end
            PTR_CLR:     ptr_next = '0;
            PTR_CURSOR:  ptr_next = cur_addr_x[AW-1:0];
            PTR_ROW_END:
            begin
                ptr_next  = row_end_x[AW-1:0];
                kcnt_next = CW'(COLUMNS - 1);
            end
            default:     ptr_next = ptr_reg;
        endcase
        if (accept)
        begin
            ptr_next = '0;
        end
    end

    always_comb
    begin
        attr_next = attr_reg;
        if (cfg_write)
        begin
            attr_next = cfg_data;
        end
    end

    always_comb
    begin
        data_next = data_reg;
        if (accept)
        begin
            data_next = '0;
        end
        else if (uw.latch_data)
        begin
            data_next = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            ptr_reg  <= '0;
            kcnt_reg <= '0;
            scr_reg  <= 1'b0;
            attr_reg <= RESET_ATTR;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            ptr_reg  <= ptr_next;
            kcnt_reg <= kcnt_next;
            scr_reg  <= scr_next;
            attr_reg <= attr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (accept)
        begin
            cmd_ch_reg   <= char_code;
            cmd_addr_reg <= cell_address;
        end
        if (emit)
        begin
            out_loc_reg  <= cur_addr_x[LOC_W-1:0];
            out_row_reg  <= row_x[ROW_W-1:0];
            out_col_reg  <= col_x[COL_W-1:0];
            out_data_reg <= data_reg;
            out_scr_reg  <= scr_reg;
        end
    end

    assign cursor_index    = out_loc_reg;
    assign cursor_row      = out_row_reg;
    assign cursor_column   = out_col_reg;
    assign read_data       = out_data_reg;
    assign scrolled        = out_scr_reg;

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(row_reg) < ROWS) && (int'(col_reg) < COLUMNS))
        else $error("cursor left the screen");

    a_scroll_at_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        scr_reg |-> (at_last_row && (col_reg == '0)))
        else $error("scroll pending with cursor off the start of the last row");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        uw.we |-> (int'(ptr_reg) < CELLS))
        else $error("cell write beyond the store");

    a_prev_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.cur_op == CUR_PREV_ROW) |-> ((row_reg != '0) && (col_reg == '0)))
        else $error("backspace stepped above the first row");

endmodule

// ----- rtl/ttw_sequencer.sv -----
// Microcode sequencer of the text terminal writer: step counter, program
// table, branch logic and the transaction handshakes. Depends on ttw_pkg.

module ttw_sequencer
    import ttw_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [OP_W-1:0] op,
    input  logic            out_stall,
    input  flags_t          flags,
    output logic            in_stall,
    output logic            out_valid,
    output uword_t          uw,
    output logic            accept,
    output logic            emit
);

    upc_t upc_reg, upc_next;
    logic out_valid_reg, out_valid_next;
    logic cond_hit;
    upc_t dispatch;

    assign uw = ucode_rom(upc_reg);

    always_comb
    begin
        case (uw.cond)
            COND_IS_NL:     cond_hit = flags.is_nl;
            COND_SCR_PEND:  cond_hit = flags.scr_pend;
            COND_LAST_CELL: cond_hit = flags.last_cell;
            COND_LAST_COPY: cond_hit = flags.last_copy;
            COND_ADDR_OOR:  cond_hit = flags.addr_oor;
            COND_HOME:      cond_hit = flags.home;
            COND_COL_NZ:    cond_hit = flags.col_nz;
            COND_CHAR_NS:   cond_hit = flags.char_ns;
            COND_KCNT_ZERO: cond_hit = flags.kcnt_zero;
            default:        cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        case (op_t'(op))
            OP_PUT:   dispatch = ST_PUT;
            OP_BKSP:  dispatch = ST_BKSP;
            OP_CLEAR: dispatch = ST_CLEAR;
            OP_READ:  dispatch = ST_READ;
            default:  dispatch = ST_FETCH;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_stall = (uw.seq != SEQ_FETCH);
        accept   = (uw.seq == SEQ_FETCH) && in_valid;
        emit     = (uw.seq == SEQ_DONE) && !(out_valid_reg && out_stall);
    end

    // Next step.
    always_comb
    begin
        case (uw.seq)
            SEQ_NEXT:   upc_next = upc_reg + upc_t'(1);
            SEQ_JUMP:   upc_next = uw.target;
            SEQ_BRANCH: upc_next = cond_hit ? uw.target : upc_reg + upc_t'(1);
            SEQ_LOOP:   upc_next = cond_hit ? upc_reg + upc_t'(1) : upc_reg;
            SEQ_FETCH:  upc_next = in_valid ? dispatch : upc_reg;
            SEQ_DONE:   upc_next = emit ? ST_FETCH : upc_reg;
            default:    upc_next = ST_FETCH;
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("second command taken while one is in progress");

    a_upc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= ST_DONE)
        else $error("step counter outside the program");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("result loaded but not presented");

endmodule

// ----- test/ttw_checker.sv -----
// Checker for the text terminal writer: watches the command, result and configuration ports,
// keeps its own copy of the cell store and cursor, and compares every result transaction.
// Depends on ttw_pkg for field widths, character constants and the command encoding.

module ttw_checker
    import ttw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [ADDR_W-1:0] cell_address,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [LOC_W-1:0]  cursor_index,
    input  logic [ROW_W-1:0]  cursor_row,
    input  logic [COL_W-1:0]  cursor_column,
    input  logic [CELL_W-1:0] read_data,
    input  logic              scrolled,
    input  logic              cfg_write,
    input  logic [ATTR_W-1:0] cfg_data,
    output int                pending,
    output int                mismatches,
    output int                checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = ROWS * COLUMNS;

    typedef struct packed {
        logic [LOC_W-1:0]  location;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [CELL_W-1:0] data;
        logic              scroll_flag;
    } cursor_report_t;

    logic [CELL_W-1:0] screen [0:CELLS-1];
    int                row_pos;
    int                col_pos;
    logic [ATTR_W-1:0] blank_attr;
    cursor_report_t    awaited_reports[$];
    int                error_count;
    int                report_count;

    function automatic logic [CELL_W-1:0] blank_cell();
        return {blank_attr, SPACE_CHAR};
    endfunction

    // Updates the local store and cursor for one command and returns the report it causes.
    function automatic cursor_report_t apply_command(op_t cmd, logic [CHAR_W-1:0] ch,
                                                     logic [ADDR_W-1:0] addr);
        cursor_report_t r;
        int             base;
        int             k;
        int             last;
        bit             found;
        r = '0;
        case (cmd)
            OP_PUT:
            begin
                if (ch == NEWLINE_CHAR)
                begin
                    row_pos++;
                    col_pos = 0;
                end
                else
                begin
                    screen[row_pos * COLUMNS + col_pos][CHAR_W-1:0] = ch;
                    col_pos++;
                end
                if (col_pos >= COLUMNS)
                begin
                    row_pos++;
                    col_pos = 0;
                end
                if (row_pos >= ROWS)
                begin
                    for (k = 0; k + COLUMNS < CELLS; k++)
                        screen[k] = screen[k + COLUMNS];
                    for (k = (ROWS - 1) * COLUMNS; k < CELLS; k++)
                        screen[k] = blank_cell();
                    row_pos = ROWS - 1;
                    r.scroll_flag = 1'b1;
                end
            end
            OP_BKSP:
            begin
                if (row_pos != 0 || col_pos != 0)
                begin
                    if (col_pos == 0)
                    begin
                        // Step to the previous row and land just past its last visible character.
                        row_pos--;
                        base = row_pos * COLUMNS;
                        found = 1'b0;
                        last = 0;
                        for (k = COLUMNS - 1; k >= 0 && !found; k--)
                        begin
                            if (screen[base + k][CHAR_W-1:0] != SPACE_CHAR)
                            begin
                                found = 1'b1;
                                last = k;
                            end
                        end
                        if (!found || screen[base + last][CHAR_W-1:0] == NEWLINE_CHAR)
                            col_pos = 0;
                        else if (last + 1 >= COLUMNS)
                            col_pos = COLUMNS - 1;
                        else
                            col_pos = last + 1;
                    end
                    else
                    begin
                        col_pos--;
                    end
                    screen[row_pos * COLUMNS + col_pos][CHAR_W-1:0] = SPACE_CHAR;
                end
            end
            OP_CLEAR:
            begin
                for (k = 0; k < CELLS; k++)
                    screen[k] = blank_cell();
            end
            default:
            begin
                if (int'(addr) < CELLS)
                    r.data = screen[addr];
            end
        endcase
        r.location = LOC_W'(row_pos * COLUMNS + col_pos);
        r.row = ROW_W'(row_pos);
        r.column = COL_W'(col_pos);
        return r;
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t ns: mismatch in %s: expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, name, want, want, got, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cursor_report_t want;
        int             k;
        if (!rst_n)
        begin
            for (k = 0; k < CELLS; k++)
                screen[k] = {RESET_ATTR, SPACE_CHAR};
            row_pos = 0;
            col_pos = 0;
            blank_attr = RESET_ATTR;
            awaited_reports.delete();
            error_count = 0;
            report_count = 0;
            pending <= 0;
            mismatches <= 0;
            checked <= 0;
        end
        else
        begin
            // Results are matched before new commands are queued so that a stray result
            // can never be paired with a command accepted on the same edge.
            if (out_valid && !out_stall)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $display("%0t ns: result transaction arrived with nothing expected", $time);
                    error_count++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    compare_field("cursor_index", int'(want.location), int'(cursor_index));
                    compare_field("cursor_row", int'(want.row), int'(cursor_row));
                    compare_field("cursor_column", int'(want.column), int'(cursor_column));
                    compare_field("read_data", int'(want.data), int'(read_data));
                    compare_field("scrolled", int'(want.scroll_flag), int'(scrolled));
                    report_count++;
                end
            end
            if (cfg_write)
                blank_attr = cfg_data;
            if (in_valid && !in_stall)
                awaited_reports.push_back(apply_command(op_t'(op), char_code, cell_address));
            pending <= awaited_reports.size();
            mismatches <= error_count;
            checked <= report_count;
        end
    end

endmodule

// ----- test/tb_text_terminal_writer.sv -----
// Testbench top for the text terminal writer: clock, reset, command stimulus, result-side
// stalls, blank attribute changes and the final verdict. Depends on ttw_pkg and ttw_checker.

module tb_text_terminal_writer
    import ttw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CYCLE_LIMIT = 10_000_000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;
    logic              out_valid;
    logic              out_stall;
    logic [LOC_W-1:0]  cursor_index;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic [CELL_W-1:0] read_data;
    logic              scrolled;
    logic              cfg_write;
    logic [ATTR_W-1:0] cfg_data;

    int                pending;
    int                mismatches;
    int                checked;
    int                cycle_count = 0;
    int                stall_hold;
    int                op_count [4];
    logic [LOC_W-1:0]  last_cursor = '0;
    logic [ATTR_W-1:0] mid_attr;

    text_terminal_writer #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .char_code(char_code),
        .cell_address(cell_address),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cursor_index(cursor_index),
        .cursor_row(cursor_row),
        .cursor_column(cursor_column),
        .read_data(read_data),
        .scrolled(scrolled),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data)
    );

    ttw_checker #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .char_code(char_code),
        .cell_address(cell_address),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cursor_index(cursor_index),
        .cursor_row(cursor_row),
        .cursor_column(cursor_column),
        .read_data(read_data),
        .scrolled(scrolled),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .pending(pending),
        .mismatches(mismatches),
        .checked(checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run exceeded %0d cycles with %0d results outstanding", CYCLE_LIMIT, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result-side back-pressure: runs of stall or no stall, mostly short, now and then long.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_hold <= 0;
        end
        else if (stall_hold == 0)
        begin
            out_stall <= ($urandom_range(0, 3) == 0);
            stall_hold <= ($urandom_range(0, 11) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(0, 2);
        end
        else
        begin
            stall_hold <= stall_hold - 1;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            last_cursor <= cursor_index;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // Called at a rising edge; returns at the edge where the command transaction is taken.
    task automatic send_command(op_t cmd, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= cmd;
        char_code <= ch;
        cell_address <= addr;
        op_count[cmd]++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_blank_attribute(logic [ATTR_W-1:0] attr);
        drain_results();
        cfg_write <= 1'b1;
        cfg_data <= attr;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic put_char(logic [CHAR_W-1:0] ch);
        send_command(OP_PUT, ch, ADDR_W'($urandom));
    endtask

    task automatic read_cell(int addr);
        send_command(OP_READ, CHAR_W'($urandom), ADDR_W'(addr));
    endtask

    task automatic backspace();
        send_command(OP_BKSP, CHAR_W'($urandom), ADDR_W'($urandom));
    endtask

    task automatic run_directed();
        backspace();                  // at home: nothing moves
        read_cell(0);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(SPACE_CHAR);
        backspace();                  // inside a row
        put_char(NEWLINE_CHAR);
        backspace();                  // back onto row 0 past its last visible character
        put_char(NEWLINE_CHAR);
        put_char(NEWLINE_CHAR);
        backspace();                  // previous row holds only spaces
        read_cell(1);
        read_cell(COLUMNS * ROWS - 1);
        read_cell(COLUMNS * ROWS);    // first address past the store
        read_cell((1 << ADDR_W) - 1);
        send_command(OP_CLEAR, 8'hFF, '1);
        read_cell(2);
        put_char(8'h7E);
        read_cell(int'(last_cursor));
    endtask

    // Random traffic built from terminal-like bursts with a little pure noise mixed in.
    task automatic run_random(int budget);
        int sent;
        int kind;
        int n;
        int i;
        int addr;
        sent = 0;
        while (sent < budget)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(78, 84) : $urandom_range(1, 20);
                for (i = 0; i < n; i++)
                    put_char(($urandom_range(0, 5) == 0) ? SPACE_CHAR : CHAR_W'($urandom));
            end
            else if (kind < 38)
            begin
                // A full row of visible characters, then erase back across the wrap.
                put_char(NEWLINE_CHAR);
                for (i = 0; i < COLUMNS; i++)
                    put_char(CHAR_W'($urandom_range(8'h21, 8'hFF)));
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    backspace();
                n = n + COLUMNS + 1;
            end
            else if (kind < 52)
            begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 26) : $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    put_char(NEWLINE_CHAR);
            end
            else if (kind < 66)
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    backspace();
            end
            else if (kind < 86)
            begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 3))
                        0, 1: addr = int'(last_cursor) - int'($urandom_range(0, 100));
                        2: addr = $urandom_range(0, (1 << ADDR_W) - 1);
                        default: addr = $urandom_range(COLUMNS * (ROWS - 1), (1 << ADDR_W) - 1);
                    endcase
                    read_cell((addr < 0) ? 0 : addr);
                end
            end
            else if (kind < 89)
            begin
                n = 1;
                send_command(OP_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom));
            end
            else
            begin
                n = $urandom_range(1, 5);
                for (i = 0; i < n; i++)
                    send_command(op_t'($urandom_range(0, 3)), CHAR_W'($urandom),
                                 ADDR_W'($urandom));
            end
            sent += n;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_PUT;
        char_code = '0;
        cell_address = '0;
        cfg_write = 1'b0;
        cfg_data = '0;
        op_count = '{default: 0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        set_blank_attribute(8'h00);
        run_random(130);
        set_blank_attribute(8'hFF);
        run_random(130);
        mid_attr = ATTR_W'($urandom_range(1, 254));
        set_blank_attribute(mid_attr);
        run_random(140);

        drain_results();
        repeat (20) @(posedge clk);

        $display("Covered %0d commands: %0d put, %0d backspace, %0d clear, %0d read; %0d results checked.",
                 op_count[OP_PUT] + op_count[OP_BKSP] + op_count[OP_CLEAR] + op_count[OP_READ],
                 op_count[OP_PUT], op_count[OP_BKSP], op_count[OP_CLEAR], op_count[OP_READ],
                 checked);
        $display("Blank attributes used: 0x0f after reset, 0x00, 0xff and 0x%02h; mismatches: %0d.",
                 mid_attr, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ttw_pkg.sv
rtl/ttw_ram.sv
rtl/ttw_datapath.sv
rtl/ttw_sequencer.sv
rtl/text_terminal_writer.sv
test/ttw_checker.sv
test/tb_text_terminal_writer.sv
